// ===== rtl/core/swp_pkg.sv =====
// ----------------------------------------------------------------------------
// swp_pkg
// Types, constants and helpers shared by the script line word splitter.
// ----------------------------------------------------------------------------
package swp_pkg;

    localparam int MAX_WORDS_BOUND    = 16;
    localparam int MAX_WORD_LEN_BOUND = 64;

    localparam int BYTE_W   = 8;
    localparam int WIDX_W   = 4;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int NSLOT    = 3;
    localparam int SLOT_W   = 2;

    localparam logic [COUNT_W-1:0] MW_BOUND = COUNT_W'(MAX_WORDS_BOUND);
    localparam logic [POS_W-1:0]   ML_BOUND = POS_W'(MAX_WORD_LEN_BOUND);

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORDS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WORD_LEN = 1'b1;

    localparam logic ERR_WORDS = 1'b0;
    localparam logic ERR_LEN   = 1'b1;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_DONE = 2'd2,
        K_ERR  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              has_byte;
        logic              line_end;
    } t_item;

    typedef struct packed {
        t_kind              kind;
        logic [WIDX_W-1:0]  word_index;
        logic [POS_W-1:0]   byte_pos;
        logic [BYTE_W-1:0]  word_byte;
        logic [COUNT_W-1:0] word_count;
        logic               error_code;
        logic               last;
    } t_result;

    typedef struct packed {
        t_result [NSLOT-1:0] slot;
        logic [SLOT_W-1:0]   cnt;
    } t_bundle;

    function automatic t_result mk_result(
        input t_kind              kind,
        input logic [COUNT_W-1:0] widx,
        input logic [POS_W-1:0]   pos,
        input logic [BYTE_W-1:0]  data,
        input logic [COUNT_W-1:0] count,
        input logic               err
    );
        t_result r;
        r.kind       = kind;
        r.word_index = widx[WIDX_W-1:0];
        r.byte_pos   = pos;
        r.word_byte  = data;
        r.word_count = count;
        r.error_code = err;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/swp_if.sv =====
// ----------------------------------------------------------------------------
// swp_in_if / swp_out_if
// Valid/ready channels for line bytes in and results out.
// ----------------------------------------------------------------------------
interface swp_in_if;
    logic                       valid;
    logic                       ready;
    logic [swp_pkg::BYTE_W-1:0] in_byte;
    logic                       has_byte;
    logic                       line_end;

    modport source (output valid, in_byte, has_byte, line_end, input ready);
    modport sink   (input valid, in_byte, has_byte, line_end, output ready);
endinterface

interface swp_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [swp_pkg::WIDX_W-1:0]  word_index;
    logic [swp_pkg::POS_W-1:0]   byte_pos;
    logic [swp_pkg::BYTE_W-1:0]  word_byte;
    logic [swp_pkg::COUNT_W-1:0] word_count;
    logic                        error_code;
    logic                        last;

    modport source (output valid, kind, word_index, byte_pos, word_byte, word_count,
                    error_code, last, input ready);
    modport sink   (input valid, kind, word_index, byte_pos, word_byte, word_count,
                    error_code, last, output ready);
endinterface

// ===== rtl/core/script_line_word_splitter.sv =====
// ----------------------------------------------------------------------------
// script_line_word_splitter
// Splits script line bytes into words, end markers, done and error results.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per line byte (in_byte, has_byte, line_end);
//   has_byte low with line_end high only closes the line. o_res carries
//   results: word bytes, word ends, line done with the word count, or an
//   error; last marks the final result of a request.
//   i_cfg_we/i_cfg_idx/i_cfg_data write max_words (index 0) and
//   max_word_len (index 1); the user must write them only while idle, as
//   the block does not enforce it. A request's first result is registered,
//   shown in the cycle after acceptance. Throughput: one request per cycle
//   while each yields at most one result and the receiver is ready; else the
//   next waits until the last result is taken, one result a cycle when ready.
//   Reset clears the line state, restores the limits to 16 and 64 and empties
//   the output register. When the receiver stalls, the pending result holds
//   and i_req.ready drops once the next request cannot be taken.
// ----------------------------------------------------------------------------
module script_line_word_splitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    swp_in_if.sink                          i_req,
    swp_out_if.source                       o_res
);

    swp_pkg::t_item   item;
    swp_pkg::t_bundle bundle;
    swp_pkg::t_result res;
    logic             load_ok;
    logic             fire;

    assign item.in_byte  = i_req.in_byte;
    assign item.has_byte = i_req.has_byte;
    assign item.line_end = i_req.line_end;

    assign i_req.ready = load_ok;
    assign fire        = i_req.valid && load_ok;

    swp_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_item     (item),
        .o_bundle   (bundle)
    );

    swp_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_bundle  (bundle),
        .o_load_ok (load_ok),
        .o_valid   (o_res.valid),
        .i_ready   (o_res.ready),
        .o_result  (res)
    );

    assign o_res.kind       = res.kind;
    assign o_res.word_index = res.word_index;
    assign o_res.byte_pos   = res.byte_pos;
    assign o_res.word_byte  = res.word_byte;
    assign o_res.word_count = res.word_count;
    assign o_res.error_code = res.error_code;
    assign o_res.last       = res.last;

endmodule

// ===== rtl/core/swp_step.sv =====
// ----------------------------------------------------------------------------
// swp_step
// Line state, limit registers and per-request result generation.
// ----------------------------------------------------------------------------
module swp_step (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [swp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [swp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_fire,
    input  swp_pkg::t_item                  i_item,
    output swp_pkg::t_bundle                o_bundle
);

    logic [swp_pkg::COUNT_W-1:0] r_max_words;
    logic [swp_pkg::POS_W-1:0]   r_max_len;
    logic [swp_pkg::COUNT_W-1:0] r_words, n_words;
    logic [swp_pkg::POS_W-1:0]   r_bytes, n_bytes;
    logic                        r_skip, n_skip;

    logic [swp_pkg::COUNT_W-1:0] mw;
    logic [swp_pkg::POS_W-1:0]   ml;

    assign mw = (r_max_words > swp_pkg::MW_BOUND) ? swp_pkg::MW_BOUND : r_max_words;
    assign ml = (r_max_len > swp_pkg::ML_BOUND) ? swp_pkg::ML_BOUND : r_max_len;

    always_comb begin
        swp_pkg::t_bundle            b;
        logic [swp_pkg::SLOT_W-1:0]  cnt;
        logic [swp_pkg::COUNT_W-1:0] w;
        logic [swp_pkg::POS_W-1:0]   p;
        logic                        s;
        logic                        act;
        logic                        sep;
        logic                        semi;

        b    = '0;
        cnt  = '0;
        w    = r_words;
        p    = r_bytes;
        s    = r_skip;
        act  = i_item.has_byte && !r_skip;
        sep  = (i_item.in_byte == swp_pkg::CH_SPACE) || (i_item.in_byte == swp_pkg::CH_TAB)
            || (i_item.in_byte == swp_pkg::CH_COMMA);
        semi = (i_item.in_byte == swp_pkg::CH_SEMI);

        if (act) begin
            if (sep || semi) begin
                if (p != '0) begin
                    b.slot[cnt] = swp_pkg::mk_result(swp_pkg::K_END, w, p, '0, '0, 1'b0);
                    cnt = cnt + 2'd1;
                    w   = w + 5'd1;
                    p   = '0;
                end
                if (semi) begin
                    b.slot[cnt] = swp_pkg::mk_result(swp_pkg::K_DONE, '0, '0, '0, w, 1'b0);
                    cnt = cnt + 2'd1;
                    s   = 1'b1;
                end
            end else if (w >= mw) begin
                b.slot[cnt] = swp_pkg::mk_result(swp_pkg::K_ERR, '0, '0, '0, '0,
                                                 swp_pkg::ERR_WORDS);
                cnt = cnt + 2'd1;
                s   = 1'b1;
            end else if (p >= ml) begin
                b.slot[cnt] = swp_pkg::mk_result(swp_pkg::K_ERR, '0, '0, '0, '0,
                                                 swp_pkg::ERR_LEN);
                cnt = cnt + 2'd1;
                s   = 1'b1;
            end else begin
                b.slot[cnt] = swp_pkg::mk_result(swp_pkg::K_BYTE, w, p, i_item.in_byte,
                                                 '0, 1'b0);
                cnt = cnt + 2'd1;
                p   = p + 7'd1;
            end
        end

        if (i_item.line_end) begin
            if (!s) begin
                if (p != '0) begin
                    b.slot[cnt] = swp_pkg::mk_result(swp_pkg::K_END, w, p, '0, '0, 1'b0);
                    cnt = cnt + 2'd1;
                    w   = w + 5'd1;
                end
                b.slot[cnt] = swp_pkg::mk_result(swp_pkg::K_DONE, '0, '0, '0, w, 1'b0);
                cnt = cnt + 2'd1;
            end
            w = '0;
            p = '0;
            s = 1'b0;
        end

        if (cnt != '0) begin
            b.slot[cnt - 2'd1].last = 1'b1;
        end
        b.cnt    = cnt;
        o_bundle = b;
        n_words  = w;
        n_bytes  = p;
        n_skip   = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_words <= swp_pkg::MW_BOUND;
            r_max_len   <= swp_pkg::ML_BOUND;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swp_pkg::CFG_MAX_WORDS:    r_max_words <= i_cfg_data[swp_pkg::COUNT_W-1:0];
                swp_pkg::CFG_MAX_WORD_LEN: r_max_len   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_bytes <= '0;
            r_skip  <= 1'b0;
        end else if (i_fire) begin
            r_words <= n_words;
            r_bytes <= n_bytes;
            r_skip  <= n_skip;
        end
    end

    a_line_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.line_end |=> (r_words == '0) && (r_bytes == '0) && !r_skip)
        else $error("line state not cleared at line end");

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bytes <= swp_pkg::ML_BOUND) && (r_words <= swp_pkg::MW_BOUND))
        else $error("word or byte count beyond bound");

endmodule

// ===== rtl/core/swp_emit.sv =====
// ----------------------------------------------------------------------------
// swp_emit
// Result register: holds up to three results of one request, sends one a cycle while i_ready.
// ----------------------------------------------------------------------------
module swp_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  swp_pkg::t_bundle  i_bundle,
    output logic              o_load_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output swp_pkg::t_result  o_result
);

    swp_pkg::t_result [swp_pkg::NSLOT-1:0] r_slot;
    logic [swp_pkg::SLOT_W-1:0]            r_cnt;
    logic                                  take;

    assign o_valid   = (r_cnt != '0);
    assign take      = o_valid && i_ready;
    assign o_load_ok = (r_cnt == '0) || ((r_cnt == 2'd1) && i_ready);
    assign o_result  = r_slot[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_fire) begin
            r_cnt <= i_bundle.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_slot <= i_bundle.slot;
        end else if (take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    a_last_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> r_slot[0].last)
        else $error("final result of a request without last");

    a_no_early_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > 2'd1) |-> !r_slot[0].last)
        else $error("last flagged before the final result");

endmodule
